FILE: sv/section_key_value_tokenizer_defines.svh
// assertion macros used by the tokenizer checker
`ifndef SECTION_KEY_VALUE_TOKENIZER_DEFINES_SVH
`define SECTION_KEY_VALUE_TOKENIZER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SKVT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define SKVT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/skvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skvt_pkg
// Types, codes and character constants for the section/key/value tokenizer.
// ----------------------------------------------------------------------------
package skvt_pkg;

   // sizing defaults
   localparam int STACK_DEPTH_DEFAULT = 16;
   localparam logic [4:0] SECTION_MAX = 5'd16;

   // parse modes
   typedef logic [2:0] mode_type;
   localparam mode_type MODE_NONE     = 3'd0;
   localparam mode_type MODE_NAME     = 3'd1;
   localparam mode_type MODE_SECTION  = 3'd2;
   localparam mode_type MODE_KEY      = 3'd3;
   localparam mode_type MODE_VALUE    = 3'd4;
   localparam mode_type MODE_LCOMMENT = 3'd5;
   localparam mode_type MODE_BCOMMENT = 3'd6;

   // event codes
   typedef logic [3:0] event_type;
   localparam event_type EV_NONE      = 4'd0;
   localparam event_type EV_NAME_CHAR = 4'd1;
   localparam event_type EV_NAME_END  = 4'd2;
   localparam event_type EV_OPEN      = 4'd3;
   localparam event_type EV_CLOSE     = 4'd4;
   localparam event_type EV_KEY_CHAR  = 4'd5;
   localparam event_type EV_KEY_END   = 4'd6;
   localparam event_type EV_VAL_CHAR  = 4'd7;
   localparam event_type EV_PAIR_END  = 4'd8;
   localparam event_type EV_ERROR     = 4'd9;

   // error codes
   typedef logic [3:0] err_type;
   localparam err_type ERR_NONE     = 4'd0;
   localparam err_type ERR_LBRACKET = 4'd1;
   localparam err_type ERR_RBRACKET = 4'd2;
   localparam err_type ERR_LBRACE   = 4'd3;
   localparam err_type ERR_RBRACE   = 4'd4;
   localparam err_type ERR_EQUALS   = 4'd5;
   localparam err_type ERR_SEMI     = 4'd6;
   localparam err_type ERR_CLOSER   = 4'd7;
   localparam err_type ERR_OVERFLOW = 4'd8;

   // stack cell operations
   typedef logic [1:0] stack_op_type;
   localparam stack_op_type OP_HOLD = 2'd0;
   localparam stack_op_type OP_PUSH = 2'd1;
   localparam stack_op_type OP_POP  = 2'd2;
   localparam stack_op_type OP_LOAD = 2'd3;

   // characters
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_STAR     = 8'h2A;
   localparam logic [7:0] CH_SLASH    = 8'h2F;
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_EQUALS   = 8'h3D;
   localparam logic [7:0] CH_UPPER_A  = 8'h41;
   localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_LBRACE   = 8'h7B;
   localparam logic [7:0] CH_RBRACE   = 8'h7D;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   // decoder result for one character
   typedef struct packed {
      stack_op_type op;
      mode_type     new_mode;
      logic         sec_inc;
      logic         sec_dec;
      event_type    ev;
      logic [7:0]   chr;
      err_type      err;
   } dec_type;

   // one result transaction
   typedef struct packed {
      event_type  ev;
      logic       doc_ok;
      mode_type   mode_now;
      logic [4:0] depth;
      err_type    err;
      logic [7:0] chr;
   } rsp_type;

endpackage

FILE: sv/skvt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skvt_cell
// One entry of the shifting mode stack: takes its upper neighbor on a push,
// its lower neighbor on a pop, the supplied mode on a load.
// ----------------------------------------------------------------------------
module skvt_cell
   import skvt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         enable,
   input  stack_op_type op,
   input  mode_type     upper_mode,
   input  mode_type     lower_mode,
   output mode_type     mode_ff
);

   mode_type mode_in;

   // next entry value
   always_comb begin
      mode_in = mode_ff;
      if (enable) begin
         unique case (op)
            OP_HOLD: mode_in = mode_ff;
            OP_PUSH: mode_in = upper_mode;
            OP_POP:  mode_in = lower_mode;
            OP_LOAD: mode_in = upper_mode;
            default: mode_in = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NONE;
      end else begin
         mode_ff <= mode_in;
      end
   end

endmodule

FILE: sv/skvt_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skvt_decode
// Normalizes one character and classifies it against the top parse mode.
// ----------------------------------------------------------------------------
module skvt_decode
   import skvt_pkg::*;
(
   input  logic [7:0] ch,
   input  logic [7:0] next_ch,
   input  logic       has_next,
   input  mode_type   top_mode,
   input  logic       stack_full,
   output dec_type    dec
);

   logic [7:0] c;
   logic       is_tok;
   logic       in_comment;
   logic       is_bracket_like;

   // character normalization
   always_comb begin
      c = ch;
      if (ch == CH_CR) begin
         c = CH_LF;
      end else if (ch == CH_TAB) begin
         c = CH_SPACE;
      end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
         c = ch + CASE_OFFSET;
      end
   end

   assign is_tok = (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_LBRACKET) ||
                   (c == CH_RBRACKET) || (c == CH_SEMI) || (c == CH_EQUALS) ||
                   (c == CH_SLASH) || (c == CH_STAR) || (c == CH_LF);
   assign in_comment = (top_mode == MODE_LCOMMENT) || (top_mode == MODE_BCOMMENT);
   assign is_bracket_like = (c == CH_LBRACKET) || (c == CH_RBRACKET) ||
                            (c == CH_LBRACE) || (c == CH_RBRACE) ||
                            (c == CH_SLASH) || (c == CH_STAR);

   // classification
   always_comb begin
      dec          = '0;
      dec.op       = OP_HOLD;
      dec.new_mode = MODE_NONE;
      dec.ev       = EV_NONE;
      dec.err      = ERR_NONE;
      if (is_tok) begin
         priority if (top_mode == MODE_VALUE && is_bracket_like) begin
            dec.ev  = EV_VAL_CHAR;
            dec.chr = c;
         end else if (c == CH_LBRACKET) begin
            if (top_mode == MODE_NONE || top_mode == MODE_SECTION) begin
               if (stack_full) begin
                  dec.err = ERR_OVERFLOW;
               end else begin
                  dec.op       = OP_PUSH;
                  dec.new_mode = MODE_NAME;
               end
            end else begin
               dec.err = ERR_LBRACKET;
            end
         end else if (c == CH_RBRACKET) begin
            if (top_mode == MODE_NAME) begin
               dec.op      = OP_POP;
               dec.sec_inc = 1'b1;
               dec.ev      = EV_NAME_END;
            end else begin
               dec.err = ERR_RBRACKET;
            end
         end else if (c == CH_LBRACE) begin
            if (top_mode == MODE_NONE || top_mode == MODE_SECTION) begin
               if (stack_full) begin
                  dec.err = ERR_OVERFLOW;
               end else begin
                  dec.op       = OP_PUSH;
                  dec.new_mode = MODE_SECTION;
                  dec.ev       = EV_OPEN;
               end
            end else begin
               dec.err = ERR_LBRACE;
            end
         end else if (c == CH_RBRACE) begin
            if (top_mode == MODE_SECTION) begin
               dec.op      = OP_POP;
               dec.sec_dec = 1'b1;
               dec.ev      = EV_CLOSE;
            end else begin
               dec.err = ERR_RBRACE;
            end
         end else if (c == CH_EQUALS) begin
            // key end swaps the top entry for value mode
            if (top_mode == MODE_KEY) begin
               dec.op       = OP_LOAD;
               dec.new_mode = MODE_VALUE;
               dec.ev       = EV_KEY_END;
            end else if (!in_comment) begin
               dec.err = ERR_EQUALS;
            end
         end else if (c == CH_SEMI) begin
            if (top_mode == MODE_VALUE) begin
               dec.op = OP_POP;
               dec.ev = EV_PAIR_END;
            end else if (!in_comment) begin
               dec.err = ERR_SEMI;
            end
         end else if (c == CH_SLASH) begin
            // comment opener
            if (has_next && (next_ch == CH_SLASH || next_ch == CH_STAR) && !in_comment) begin
               if (stack_full) begin
                  dec.err = ERR_OVERFLOW;
               end else begin
                  dec.op       = OP_PUSH;
                  dec.new_mode = (next_ch == CH_SLASH) ? MODE_LCOMMENT : MODE_BCOMMENT;
               end
            end
         end else if (c == CH_STAR) begin
            // block comment closer
            if (has_next && next_ch == CH_SLASH) begin
               if (top_mode == MODE_BCOMMENT) begin
                  dec.op = OP_POP;
               end else begin
                  dec.err = ERR_CLOSER;
               end
            end
         end else begin
            // line end closes a line comment
            if (top_mode == MODE_LCOMMENT) begin
               dec.op = OP_POP;
            end
         end
      end else begin
         if (top_mode == MODE_SECTION && c != CH_SPACE) begin
            // first key character opens key mode
            if (stack_full) begin
               dec.err = ERR_OVERFLOW;
            end else begin
               dec.op       = OP_PUSH;
               dec.new_mode = MODE_KEY;
               dec.ev       = EV_KEY_CHAR;
               dec.chr      = c;
            end
         end else if (top_mode == MODE_NAME) begin
            dec.ev  = EV_NAME_CHAR;
            dec.chr = c;
         end else if (top_mode == MODE_KEY) begin
            dec.ev  = EV_KEY_CHAR;
            dec.chr = c;
         end else if (top_mode == MODE_VALUE) begin
            dec.ev  = EV_VAL_CHAR;
            dec.chr = c;
         end
      end
      // errors override the event
      if (dec.err != ERR_NONE) begin
         dec.ev  = EV_ERROR;
         dec.chr = '0;
      end
   end

endmodule

FILE: sv/section_key_value_tokenizer.sv
`timescale 1ns / 1ps
// Each result is registered in the output entry, or the skid entry when held.
// Throughput: one character per cycle while req_tready is high; the loop is
// decode of the top cell of the mode stack chain and its update in the same cycle.
// A two-entry output stage keeps req_tready high while one result waits.
// Reset (synchronous): stack to a single base entry of mode none, zero open
// sections, error flag clear, output stage empty.
// ----------------------------------------------------------------------------
// section_key_value_tokenizer
// Character tokenizer for sectioned key/value text with a shifting mode stack.
// ----------------------------------------------------------------------------
module section_key_value_tokenizer
   import skvt_pkg::*;
#(
   parameter int MODE_STACK_DEPTH = STACK_DEPTH_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   // input transaction
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] ch, [15:8] next_ch
   input  logic        req_tuser,   // [0] has_next
   // result transaction
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] char_out, [11:8] error_kind,
                                    // [16:12] section_depth, [19:17] mode_now,
                                    // [20] doc_ok, [23:21] zero
   output logic [3:0]  rsp_tuser    // [3:0] event_res
);

   localparam int CNT_W = $clog2(MODE_STACK_DEPTH + 1);

   logic             accept;
   dec_type          dec;
   stack_op_type     op_eff;
   mode_type         cell_mode [MODE_STACK_DEPTH];
   mode_type         top_next;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [4:0]       section_ff, section_in;
   logic             err_seen_ff, err_seen_in;
   logic             stack_full;
   rsp_type          new_rsp;
   rsp_type          out_ff, out_in, skid_ff, skid_in;
   logic             out_valid_ff, out_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   logic             take;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign stack_full = (count_ff == CNT_W'(MODE_STACK_DEPTH));

   // character classification against the top cell
   skvt_decode u_decode (
      .ch         (req_tdata[7:0]),
      .next_ch    (req_tdata[15:8]),
      .has_next   (req_tuser),
      .top_mode   (cell_mode[0]),
      .stack_full (stack_full),
      .dec        (dec)
   );

   // the base entry is never popped
   assign op_eff = (dec.op == OP_POP && count_ff <= CNT_W'(1)) ? OP_HOLD : dec.op;

   // mode stack chain, cell 0 holds the top
   for (genvar i = 0; i < MODE_STACK_DEPTH; i++) begin : g_cell
      stack_op_type cell_op;
      mode_type     upper;
      mode_type     lower;
      if (i == 0) begin : g_top
         assign cell_op = op_eff;
         assign upper   = dec.new_mode;
      end else begin : g_body
         assign cell_op = (op_eff == OP_LOAD) ? OP_HOLD : op_eff;
         assign upper   = cell_mode[i-1];
      end
      if (i == MODE_STACK_DEPTH - 1) begin : g_last
         assign lower = MODE_NONE;
      end else begin : g_inner
         assign lower = cell_mode[i+1];
      end
      skvt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .enable     (accept),
         .op         (cell_op),
         .upper_mode (upper),
         .lower_mode (lower),
         .mode_ff    (cell_mode[i])
      );
   end

   // top mode after this step
   always_comb begin
      unique case (op_eff)
         OP_HOLD: top_next = cell_mode[0];
         OP_PUSH: top_next = dec.new_mode;
         OP_POP:  top_next = cell_mode[1];
         OP_LOAD: top_next = dec.new_mode;
         default: top_next = cell_mode[0];
      endcase
   end

   // stack fill, section count and sticky error
   always_comb begin
      count_in    = count_ff;
      section_in  = section_ff;
      err_seen_in = err_seen_ff;
      if (accept) begin
         if (op_eff == OP_PUSH) begin
            count_in = count_ff + CNT_W'(1);
         end else if (op_eff == OP_POP) begin
            count_in = count_ff - CNT_W'(1);
         end
         if (dec.sec_inc && section_ff < SECTION_MAX) begin
            section_in = section_ff + 5'd1;
         end else if (dec.sec_dec && section_ff != 5'd0) begin
            section_in = section_ff - 5'd1;
         end
         if (dec.err != ERR_NONE) begin
            err_seen_in = 1'b1;
         end
      end
   end

   // result assembly
   always_comb begin
      new_rsp.ev       = dec.ev;
      new_rsp.chr      = dec.chr;
      new_rsp.err      = dec.err;
      new_rsp.depth    = section_in;
      new_rsp.mode_now = top_next;
      new_rsp.doc_ok   = (count_in == CNT_W'(1)) && (top_next == MODE_NONE) && !err_seen_in;
   end

   // output register with skid entry
   assign take = out_valid_ff && rsp_tready;
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || take) begin
            out_in       = new_rsp;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = new_rsp;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= CNT_W'(1);
         section_ff    <= '0;
         err_seen_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         section_ff    <= section_in;
         err_seen_ff   <= err_seen_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   // port packing
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.ev;
   assign rsp_tdata  = {3'b000, out_ff.doc_ok, out_ff.mode_now, out_ff.depth,
                        out_ff.err, out_ff.chr};

endmodule

FILE: sv/skvt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skvt_checker
// Port-level checks on the tokenizer result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "section_key_value_tokenizer_defines.svh"

module skvt_checker
   import skvt_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [3:0]  rsp_tuser
);

   logic is_err_ev;
   logic is_char_ev;

   assign is_err_ev  = (rsp_tuser == EV_ERROR);
   assign is_char_ev = (rsp_tuser == EV_NAME_CHAR) || (rsp_tuser == EV_KEY_CHAR) ||
                       (rsp_tuser == EV_VAL_CHAR);

   // an error carries a code, no character, and spoils the document
   `SKVT_ASSERT_IMPL(a_err_fields, clock, reset, rsp_tvalid && is_err_ev, (rsp_tdata[11:8] != ERR_NONE) && (rsp_tdata[7:0] == 8'h00) && !rsp_tdata[20], "error transaction with bad fields")

   // other events carry no error code, and a character only for char events
   `SKVT_ASSERT_IMPL(a_clean_fields, clock, reset, rsp_tvalid && !is_err_ev, (rsp_tdata[11:8] == ERR_NONE) && (is_char_ev || rsp_tdata[7:0] == 8'h00), "non-error transaction with bad fields")

   // a good document sits in mode none, depth never passes the limit
   `SKVT_ASSERT_IMPL(a_doc_state, clock, reset, rsp_tvalid, (!rsp_tdata[20] || rsp_tdata[19:17] == MODE_NONE) && (rsp_tdata[16:12] <= SECTION_MAX) && (rsp_tdata[23:21] == 3'b000), "inconsistent document state")

   // a stalled result holds
   `SKVT_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

endmodule

bind section_key_value_tokenizer skvt_checker u_skvt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
